>>> rtl/mavg_pkg.sv
`default_nettype none

package mavg_pkg;

	localparam int MAX_WINDOW  = 128;
	localparam int SAMPLE_BITS = 16;
	localparam int CFG_BITS    = 8;
	localparam int CFG_RESET   = 8;

	localparam int POS_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int EFF_BITS = $clog2(MAX_WINDOW + 1);
	localparam int SUM_BITS = SAMPLE_BITS + POS_BITS;
	localparam int CNT_BITS = $clog2(SUM_BITS);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [SUM_BITS-1:0]    sum_t;
	typedef logic        [SUM_BITS-1:0]    mag_t;
	typedef logic        [POS_BITS-1:0]    pos_t;
	typedef logic        [EFF_BITS-1:0]    eff_t;
	typedef logic        [CFG_BITS-1:0]    cfg_t;
	typedef logic        [CNT_BITS-1:0]    cnt_t;

	// zero counts as one, anything past the store depth saturates
	function automatic eff_t eff_size(input cfg_t cfg);
		eff_t r;
		if (cfg == '0) begin
			r = eff_t'(1);
		end else if (int'(cfg) > MAX_WINDOW) begin
			r = eff_t'(MAX_WINDOW);
		end else begin
			r = eff_t'(cfg);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/moving_average_window.sv
`default_nettype none

// Boxcar smoother over the last window_size signed samples. Each accepted
// sample word replaces the oldest entry of a ring store, updates a running
// sum, and yields one result word: the sum divided by the window size,
// truncated toward zero, with window_full set when the write position wraps.
// Writing window_size (0 acts as 1, values above the store depth saturate)
// clears the window; the store entries are marked empty by per-entry valid
// bits, so the clear takes effect at once. A sample passes through the store
// read, the sum update, the serial divider and the load of the output
// register, in that order. in_ready drops while a sample is in work and
// comes back in the cycle after the load, so no new sample is taken before
// the last one is through. A finished result waits in the output register
// without blocking the next sample; that sample's own load waits until the
// held word is taken.
module moving_average_window
	import mavg_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,

	input  wire logic    cfg_valid,
	output logic         cfg_ready,
	input  wire cfg_t    window_size,

	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire sample_t sample,

	output logic         out_valid,
	input  wire logic    out_ready,
	output sample_t      average,
	output logic         window_full
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]            state_q;
	cfg_t                  wsize_q;
	pos_t                  pos_q;
	sum_t                  sum_q;
	logic [MAX_WINDOW-1:0] vld_q;

	// per-sample work registers
	sample_t samp_q;
	pos_t    addr_q;
	logic    neg_q;
	logic    wrap_q;

	logic    out_valid_q;
	sample_t avg_q;
	logic    full_q;

	eff_t    eff_w;
	pos_t    pos_eff;
	logic    in_acc;
	logic    cfg_acc;
	sample_t rd_data;
	sample_t old_w;
	sum_t    new_sum;
	mag_t    new_mag;
	eff_t    nxt_w;
	logic    nxt_wrap;
	logic    upd;
	logic    div_busy;
	logic    div_done;
	mag_t    div_quo;
	mag_t    signed_quo;
	logic    out_load;

	assign eff_w   = eff_size(wsize_q);
	// a stale position past the window counts as zero
	assign pos_eff = (eff_t'(pos_q) >= eff_w) ? '0 : pos_q;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_acc    = in_valid && in_ready;
	assign upd       = (state_q == S_UPD);

	mavg_ram u_ram (
		.clk   (clk),
		.we    (upd),
		.waddr (addr_q),
		.wdata (samp_q),
		.re    (in_acc),
		.raddr (pos_eff),
		.rdata (rd_data)
	);

	// entries never written since the last clear read as zero
	assign old_w    = vld_q[addr_q] ? rd_data : '0;
	assign new_sum  = sum_q - sum_t'(old_w) + sum_t'(samp_q);
	assign new_mag  = new_sum[SUM_BITS-1] ? mag_t'(-new_sum) : mag_t'(new_sum);
	assign nxt_w    = eff_t'(addr_q) + 1'b1;
	assign nxt_wrap = (nxt_w >= eff_w);

	mavg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (upd),
		.dividend (new_mag),
		.divisor  (eff_w),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// truncation toward zero: divide the magnitude, then restore the sign
	assign signed_quo = neg_q ? (~div_quo + 1'b1) : div_quo;
	assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wsize_q <= cfg_t'(CFG_RESET);
			pos_q   <= '0;
			sum_q   <= '0;
			vld_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_acc) begin
						wsize_q <= window_size;
						pos_q   <= '0;
						sum_q   <= '0;
						vld_q   <= '0;
					end else if (in_acc) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					sum_q         <= new_sum;
					vld_q[addr_q] <= 1'b1;
					pos_q         <= nxt_wrap ? '0 : pos_t'(nxt_w);
					state_q       <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			samp_q <= sample;
			addr_q <= pos_eff;
		end
		if (upd) begin
			neg_q  <= new_sum[SUM_BITS-1];
			wrap_q <= nxt_wrap;
		end
	end

	// output register: holds a finished word while the next sample runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			avg_q  <= sample_t'(signed_quo[SAMPLE_BITS-1:0]);
			full_q <= wrap_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign average     = avg_q;
	assign window_full = full_q;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input accepted while previous sample still in work");

	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		eff_t'(pos_q) < eff_w)
		else $error("write position outside the window");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		upd |-> !div_busy)
		else $error("divider restarted while busy");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc |=> (sum_q == '0) && (pos_q == '0) && (vld_q == '0))
		else $error("window not cleared by size write");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result word shown without a finished division");
`endif

endmodule

`default_nettype wire

>>> rtl/mavg_ram.sv
`default_nettype none

module mavg_ram
	import mavg_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    we,
	input  wire pos_t    waddr,
	input  wire sample_t wdata,
	input  wire logic    re,
	input  wire pos_t    raddr,
	output sample_t      rdata
);

	sample_t mem [MAX_WINDOW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/mavg_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle, MSB first
module mavg_div
	import mavg_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire mag_t dividend,
	input  wire eff_t divisor,
	output logic      busy,
	output logic      done,
	output mag_t      quotient
);

	logic            busy_q;
	cnt_t            cnt_q;
	eff_t            rem_q;
	eff_t            div_q;
	mag_t            quo_q;
	logic [EFF_BITS:0] trial;
	logic            take;

	assign trial = {rem_q, quo_q[SUM_BITS-1]};
	assign take  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= cnt_t'(SUM_BITS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= eff_t'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[EFF_BITS-1:0];
			end
			quo_q <= {quo_q[SUM_BITS-2:0], take};
		end
	end

	assign busy     = busy_q;
	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mavg_pkg::*;

	// one result word as the block hands it out
	typedef struct {
		sample_t average;
		logic    window_full;
	} avg_word_t;

	// cycles without any handshake before the run is declared hung; set above the
	// long receiver hold-off below
	localparam int STALL_LIMIT  = 3000;
	localparam int TAIL_CYCLES  = 64;
	localparam int PRINT_CAP    = 40;
	localparam int HOLD_CYCLES  = 300;

	logic    clk         = 1'b0;
	logic    arst_n      = 1'b0;
	logic    cfg_valid   = 1'b0;
	logic    cfg_ready;
	cfg_t    window_size = cfg_t'(CFG_RESET);
	logic    in_valid    = 1'b0;
	logic    in_ready;
	sample_t sample      = '0;
	logic    out_valid;
	logic    out_ready   = 1'b0;
	sample_t average;
	logic    window_full;

	// idle shaping, changed per test
	int unsigned in_gap_max    = 0;
	int unsigned out_stall_max = 0;
	int unsigned hold_request  = 0;
	int unsigned ready_wait    = 0;

	int mismatch_count = 0;
	int idle_cycles    = 0;

	// predictor state: shadow of the ring store, position, sum and register
	sample_t     held_samples [MAX_WINDOW];
	int unsigned write_pos;
	longint      window_sum;
	cfg_t        win_cfg;

	// averages predicted at input accept, waiting for the output side
	avg_word_t expected_averages [$];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	moving_average_window dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.window_size(window_size),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.average    (average),
		.window_full(window_full)
	);

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP) begin
			$display("tb: mismatch at %0t: %s", $realtime, msg);
		end
		mismatch_count++;
	endtask

	// samples averaged: a zero register acts as one, big values saturate
	function automatic int unsigned window_span();
		if (win_cfg == '0) begin
			return 1;
		end
		if (int'(win_cfg) > MAX_WINDOW) begin
			return MAX_WINDOW;
		end
		return int'(win_cfg);
	endfunction

	function automatic void clear_window();
		foreach (held_samples[i]) begin
			held_samples[i] = '0;
		end
		write_pos  = 0;
		window_sum = 0;
	endfunction

	// advance the shadow ring by one accepted sample and queue the result
	task automatic predict_average(input sample_t s);
		int unsigned span;
		avg_word_t   w;
		span = window_span();
		if (write_pos >= span) begin
			write_pos = 0;
		end
		window_sum = window_sum - longint'(held_samples[write_pos]) + longint'(s);
		held_samples[write_pos] = s;
		write_pos++;
		if (write_pos >= span) begin
			write_pos = 0;
		end
		// signed longint division truncates toward zero, as the block must
		w.average     = sample_t'(window_sum / longint'(span));
		w.window_full = (write_pos == 0);
		expected_averages.push_back(w);
	endtask

	// mix of near-full-scale, near-zero and fully random values
	function automatic sample_t draw_sample();
		case ($urandom_range(0, 7))
			0: return sample_t'(32'h7fff - $urandom_range(0, 3));
			1: return sample_t'(32'h8000 + $urandom_range(0, 3));
			2: return sample_t'($urandom_range(0, 15) - 8);
			default: return sample_t'($urandom());
		endcase
	endfunction

	// one sample word: optional gap with valid low, then hold until taken
	task automatic send_sample(input sample_t v);
		int unsigned gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_average(v);
	endtask

	task automatic stop_samples();
		in_valid <= 1'b0;
	endtask

	// always spends at least one edge, so valid never drops and rises in one step
	task automatic wait_drained();
		@(posedge clk);
		while (expected_averages.size() != 0) @(posedge clk);
	endtask

	// only called with the block idle: input stopped and every result back
	task automatic write_window(input cfg_t v);
		cfg_valid   <= 1'b1;
		window_size <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		win_cfg = v;
		clear_window();
	endtask

	function automatic void pick_idling();
		case ($urandom_range(0, 2))
			0: in_gap_max = 0;
			1: in_gap_max = 3;
			default: in_gap_max = 16;
		endcase
		case ($urandom_range(0, 2))
			0: out_stall_max = 0;
			1: out_stall_max = 3;
			default: out_stall_max = 16;
		endcase
	endfunction

	// result side: compare each taken word with the oldest prediction, then
	// decide how long ready stays low before the next word
	always @(posedge clk) begin
		avg_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_averages.size() == 0) begin
				report_mismatch($sformatf("unexpected word average=%0d window_full=%0b",
					average, window_full));
			end else begin
				want = expected_averages.pop_front();
				if (average !== want.average) begin
					report_mismatch($sformatf("average %0d, want %0d",
						average, want.average));
				end
				if (window_full !== want.window_full) begin
					report_mismatch($sformatf("window_full %0b, want %0b",
						window_full, want.window_full));
				end
			end
			ready_wait = $urandom_range(0, out_stall_max);
		end
		// long hold-off asked by a test is counted here, cycle by cycle
		if (hold_request != 0) begin
			ready_wait += hold_request;
			hold_request = 0;
		end
		if (ready_wait != 0) begin
			out_ready <= 1'b0;
			ready_wait--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// hang guard: any handshake restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	// reset window of 8: full-scale steps both ways, zero, +-1; the eighth
	// word wraps the ring, later ones overwrite the oldest extremes
	task automatic test_reset_window();
		sample_t seq [10];
		seq = '{16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh0000,
			-16'sh0001, 16'sh0001, 16'sh7fff, -16'sh8000, -16'sh8000};
		in_gap_max    = 2;
		out_stall_max = 2;
		foreach (seq[i]) begin
			send_sample(seq[i]);
		end
		stop_samples();
		wait_drained();
	endtask

	// register zero acts as a window of one (every word wraps, average is the
	// sample itself); the largest register value saturates at the store depth
	task automatic test_size_extremes();
		write_window(cfg_t'(0));
		send_sample(-16'sh8000);
		send_sample(16'sh7fff);
		send_sample(-16'sh0001);
		stop_samples();
		wait_drained();
		write_window('1);
		send_sample(16'sh7fff);
		send_sample(-16'sh8000);
		send_sample(-16'sh0001);
		send_sample(16'sh0001);
		stop_samples();
		wait_drained();
	endtask

	// one phase per window setting: fill a whole window with one full-scale
	// value to reach the largest sum, then 30 random words
	task automatic test_window_sweep();
		cfg_t        sizes [$];
		int unsigned span;
		sample_t     fill;
		sizes = '{cfg_t'(1), cfg_t'(2), cfg_t'(3), cfg_t'(7), cfg_t'(16), cfg_t'(33),
			cfg_t'(64), cfg_t'(127), cfg_t'(128), cfg_t'(129), cfg_t'(255), cfg_t'(0)};
		repeat (3) sizes.push_back(cfg_t'($urandom_range(1, 40)));
		foreach (sizes[p]) begin
			pick_idling();
			write_window(sizes[p]);
			span = window_span();
			fill = (p % 2) ? 16'sh7fff : -16'sh8000;
			repeat (span) send_sample(fill);
			repeat (30) send_sample(draw_sample());
			stop_samples();
			wait_drained();
		end
	endtask

	// receiver holds off while the sender keeps offering, so the block's
	// output register fills and its input stalls
	task automatic test_backpressure();
		write_window(cfg_t'(5));
		in_gap_max    = 0;
		out_stall_max = 0;
		hold_request  = HOLD_CYCLES;
		repeat (30) send_sample(draw_sample());
		stop_samples();
		wait_drained();
	endtask

	// sender stops mid-window until every result is back, then resumes
	// without a register write: the ring must carry on where it was
	task automatic test_drain_pause();
		write_window(cfg_t'(12));
		in_gap_max    = 4;
		out_stall_max = 4;
		repeat (3) begin
			repeat (13) send_sample(draw_sample());
			stop_samples();
			wait_drained();
		end
	endtask

	// stretch with no idling on either side
	task automatic test_back_to_back();
		write_window(cfg_t'(10));
		in_gap_max    = 0;
		out_stall_max = 0;
		repeat (80) send_sample(draw_sample());
		stop_samples();
		wait_drained();
	endtask

	initial begin
		win_cfg = cfg_t'(CFG_RESET);
		clear_window();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window();
		test_size_extremes();
		test_window_sweep();
		test_backpressure();
		test_drain_pause();
		test_back_to_back();

		// anything after the last expected word is caught by the checker
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_averages.size() != 0) begin
			report_mismatch($sformatf("%0d expected words never came",
				expected_averages.size()));
		end
		if (mismatch_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
